FILE: rtl/sdc16_pkg.sv
// ----------------------------------------------------------------------------
// sdc16_pkg
// Shared types, constants and functions of the stream deframer with CRC-16.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc16_pkg;

   // Sizing
   localparam int unsigned MAX_MARK_BYTES  = 4;
   localparam int unsigned MARK_BITS       = 8 * MAX_MARK_BYTES;
   localparam int unsigned WIN_DEPTH       = MAX_MARK_BYTES + 2;
   localparam int unsigned FILL_BITS       = $clog2(WIN_DEPTH + 1);
   localparam int unsigned HUNT_FILL_BITS  = $clog2(MAX_MARK_BYTES + 1);
   localparam int unsigned COUNT_BITS      = 16;
   localparam int unsigned LEN_FIELD_BYTES = 4;
   localparam int unsigned LEN_SEEN_BITS   = 3;
   localparam int unsigned MARK_LEN_BITS   = 3;
   localparam int unsigned PATTERN_BITS    = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // CRC-16/X-25, reflected
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_XOUT = 16'hFFFF;

   // Result codes
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR    = 2'd1;
   localparam logic [1:0] STATUS_NO_PAYLOAD = 2'd2;

   // Register map (word index)
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_HEADER_PATTERN = 2'd0;
   localparam logic [1:0] REG_HEADER_LENGTH  = 2'd1;
   localparam logic [1:0] REG_TAIL_PATTERN   = 2'd2;
   localparam logic [1:0] REG_TAIL_LENGTH    = 2'd3;

   // Output queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PATTERN_BITS-1:0]  header_pattern;
      logic [MARK_LEN_BITS-1:0] header_length;
      logic [PATTERN_BITS-1:0]  tail_pattern;
      logic [MARK_LEN_BITS-1:0] tail_length;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [31:0] declared_length;
      logic [15:0] payload_count;
      logic        last;
   } rsp_item_type;

   // Up to two result items per accepted byte, first one first
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   // Mark length: zero acts as one, large values act as the maximum
   function automatic logic [MARK_LEN_BITS-1:0] clamp_len(logic [MARK_LEN_BITS-1:0] v);
      logic [MARK_LEN_BITS-1:0] r;
      r = v;
      if (v == '0) r = MARK_LEN_BITS'(1);
      else if (v > MARK_LEN_BITS'(MAX_MARK_BYTES)) r = MARK_LEN_BITS'(MAX_MARK_BYTES);
      return r;
   endfunction

   // Byte i of a pattern; bytes above the pattern width read as zero
   function automatic logic [7:0] pat_byte(logic [PATTERN_BITS-1:0] pat, int unsigned i);
      return 8'(pat >> (8 * i));
   endfunction

   // One byte folded into the CRC, bit by bit
   function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sdc16_if.sv
// ----------------------------------------------------------------------------
// sdc16 channel interfaces
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdc16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sdc16_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [1:0]  status;
   logic [31:0] declared_length;
   logic [15:0] payload_count;
   logic        last;

   modport source (output valid, output kind, output data_byte, output status,
                   output declared_length, output payload_count, output last,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input declared_length, input payload_count, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/sdc16_core.sv
// ----------------------------------------------------------------------------
// sdc16_core
// Frame state: header hunt, length field, trailer window and CRC, one byte
// per transfer, producing up to two result items per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc16_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sdc16_pkg::cfg_type cfg,
   sdc16_req_if.sink             req_chan,
   input  wire logic             room,
   output sdc16_pkg::push_type   push
);
   import sdc16_pkg::*;

   localparam logic [1:0] PHASE_HUNT   = 2'd0;
   localparam logic [1:0] PHASE_LENGTH = 2'd1;
   localparam logic [1:0] PHASE_DATA   = 2'd2;

   logic [1:0]                phase_ff, phase_in;
   logic [MARK_BITS-1:0]      hw_ff, hw_in;
   logic [HUNT_FILL_BITS-1:0] hf_ff, hf_in;
   logic [31:0]               len_ff, len_in;
   logic [LEN_SEEN_BITS-1:0]  lbs_ff, lbs_in;
   logic [7:0]                win_ff [WIN_DEPTH];
   logic [7:0]                win_in [WIN_DEPTH];
   logic [FILL_BITS-1:0]      wf_ff, wf_in;
   logic [15:0]               crc_ff, crc_in;
   logic [COUNT_BITS-1:0]     cnt_ff, cnt_in;

   logic                      accept;
   logic [7:0]                b;
   logic [MARK_LEN_BITS-1:0]  h, t;
   logic [FILL_BITS-1:0]      depth;

   // Data phase datapath
   logic                      emit_pay;
   logic [7:0]                pb;
   logic [15:0]               crc_next;
   logic [COUNT_BITS-1:0]     cnt_next;
   logic [7:0]                win_shift [WIN_DEPTH];
   logic [FILL_BITS-1:0]      wf_next;
   logic                      tail_match;
   logic [15:0]               got;
   logic [1:0]                frame_status;
   rsp_item_type              pay_item, stat_item;

   // Hunt datapath
   logic [MARK_BITS-1:0]      hw_next;
   logic [HUNT_FILL_BITS-1:0] hf_next;
   logic                      head_match;

   assign req_chan.ready = room;
   assign accept = req_chan.valid & room;
   assign b      = req_chan.in_byte;
   assign h      = clamp_len(cfg.header_length);
   assign t      = clamp_len(cfg.tail_length);
   assign depth  = FILL_BITS'(t) + FILL_BITS'(2);

   // Oldest byte of the window leaves as payload once the window is full
   always_comb begin
      emit_pay = (wf_ff >= depth);
      pb = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (FILL_BITS'(k) == depth - FILL_BITS'(1)) pb = win_ff[k];
      end
      crc_next = emit_pay ? crc_fold(crc_ff, pb) : crc_ff;
      cnt_next = (emit_pay && cnt_ff != COUNT_MAX) ? cnt_ff + COUNT_BITS'(1) : cnt_ff;
      wf_next  = emit_pay ? depth : wf_ff + FILL_BITS'(1);
   end

   // Window shift and tail compare
   always_comb begin
      win_shift[0] = b;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win_shift[k] = win_ff[k-1];
      end
      tail_match = (wf_next >= FILL_BITS'(t));
      for (int i = 0; i < MAX_MARK_BYTES; i++) begin
         if (MARK_LEN_BITS'(i) < t && win_shift[i] != pat_byte(cfg.tail_pattern, i))
            tail_match = 1'b0;
      end
      // CRC bytes sit just before the tail, high byte received first
      got = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (FILL_BITS'(k) == FILL_BITS'(t)) got[7:0] = win_shift[k];
         if (FILL_BITS'(k) == FILL_BITS'(t) + FILL_BITS'(1)) got[15:8] = win_shift[k];
      end
      if (cnt_next == '0 && (wf_next - FILL_BITS'(t)) <= FILL_BITS'(2))
         frame_status = STATUS_NO_PAYLOAD;
      else if (got == (crc_next ^ CRC_XOUT))
         frame_status = STATUS_OK;
      else
         frame_status = STATUS_CRC_ERR;
   end

   // Result items
   always_comb begin
      pay_item.kind            = KIND_PAYLOAD;
      pay_item.data_byte       = pb;
      pay_item.status          = STATUS_OK;
      pay_item.declared_length = len_ff;
      pay_item.payload_count   = 16'(cnt_next);
      pay_item.last            = 1'b0;
      stat_item.kind            = KIND_STATUS;
      stat_item.data_byte       = '0;
      stat_item.status          = frame_status;
      stat_item.declared_length = len_ff;
      stat_item.payload_count   = 16'(cnt_next);
      stat_item.last            = 1'b1;
   end

   // Header hunt
   always_comb begin
      hw_next    = {hw_ff[MARK_BITS-9:0], b};
      hf_next    = (hf_ff < HUNT_FILL_BITS'(MAX_MARK_BYTES)) ? hf_ff + HUNT_FILL_BITS'(1)
                                                              : hf_ff;
      head_match = (hf_next >= HUNT_FILL_BITS'(h));
      for (int i = 0; i < MAX_MARK_BYTES; i++) begin
         if (MARK_LEN_BITS'(i) < h && hw_next[8*i +: 8] != pat_byte(cfg.header_pattern, i))
            head_match = 1'b0;
      end
   end

   // Next state and pushes
   always_comb begin
      phase_in = phase_ff;
      hw_in    = hw_ff;
      hf_in    = hf_ff;
      len_in   = len_ff;
      lbs_in   = lbs_ff;
      win_in   = win_ff;
      wf_in    = wf_ff;
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      push     = '0;
      if (accept) begin
         case (phase_ff)
            PHASE_LENGTH: begin
               len_in = {len_ff[23:0], b};
               lbs_in = lbs_ff + LEN_SEEN_BITS'(1);
               if (lbs_in >= LEN_SEEN_BITS'(LEN_FIELD_BYTES)) begin
                  phase_in = PHASE_DATA;
                  wf_in    = '0;
                  crc_in   = CRC_INIT;
                  cnt_in   = '0;
               end
            end
            PHASE_DATA: begin
               win_in = win_shift;
               wf_in  = wf_next;
               crc_in = crc_next;
               cnt_in = cnt_next;
               if (emit_pay && tail_match) begin
                  push.num    = 2'd2;
                  push.first  = pay_item;
                  push.second = stat_item;
               end else if (emit_pay) begin
                  push.num   = 2'd1;
                  push.first = pay_item;
               end else if (tail_match) begin
                  push.num   = 2'd1;
                  push.first = stat_item;
               end
               if (tail_match) begin
                  phase_in = PHASE_HUNT;
                  hw_in    = '0;
                  hf_in    = '0;
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
               hw_in    = hw_next;
               hf_in    = hf_next;
               if (head_match) begin
                  phase_in = PHASE_LENGTH;
                  hw_in    = '0;
                  hf_in    = '0;
                  len_in   = '0;
                  lbs_in   = '0;
               end
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         hw_ff    <= '0;
         hf_ff    <= '0;
         len_ff   <= '0;
         lbs_ff   <= '0;
         wf_ff    <= '0;
         crc_ff   <= CRC_INIT;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hw_ff    <= hw_in;
         hf_ff    <= hf_in;
         len_ff   <= len_in;
         lbs_ff   <= lbs_in;
         wf_ff    <= wf_in;
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Trailer window, no reset
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   // A frame ends only from the data phase
   a_status_in_data: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> phase_ff == PHASE_DATA)
      else $error("result pushed outside the data phase");

   // Two items at once are always payload then status
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> push.first.kind == KIND_PAYLOAD && push.second.last)
      else $error("bad item order");

   // The window never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      wf_ff <= FILL_BITS'(WIN_DEPTH))
      else $error("window fill out of range");

endmodule

`default_nettype wire

FILE: rtl/sdc16_rsp_queue.sv
// ----------------------------------------------------------------------------
// sdc16_rsp_queue
// Small result queue: takes up to two items per cycle, hands one per
// transfer to the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc16_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sdc16_pkg::push_type push,
   output logic                   room,
   sdc16_rsp_if.source            rsp_chan
);
   import sdc16_pkg::*;

   rsp_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wp_ff, wp_in;
   logic [QPTR_BITS-1:0] rp_ff, rp_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;
   rsp_item_type         head;

   assign room = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign pop  = rsp_chan.valid & rsp_chan.ready;
   assign head = mem_ff[rp_ff];

   assign rsp_chan.valid           = (count_ff != '0);
   assign rsp_chan.kind            = head.kind;
   assign rsp_chan.data_byte       = head.data_byte;
   assign rsp_chan.status          = head.status;
   assign rsp_chan.declared_length = head.declared_length;
   assign rsp_chan.payload_count   = head.payload_count;
   assign rsp_chan.last            = head.last;

   // Pointer and occupancy update
   always_comb begin
      wp_in    = wp_ff + QPTR_BITS'(push.num);
      rp_in    = rp_ff + QPTR_BITS'(pop);
      count_in = count_ff + QCNT_BITS'(push.num) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) mem_ff[wp_ff] <= push.first;
      if (push.num == 2'd2) mem_ff[wp_ff + QPTR_BITS'(1)] <= push.second;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> room)
      else $error("push without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.num == 2'd0 |=> count_ff == $past(count_ff) - QCNT_BITS'(1))
      else $error("occupancy not reduced on transfer");

endmodule

`default_nettype wire

FILE: rtl/stream_deframer_crc16_unit.sv
// ----------------------------------------------------------------------------
// stream_deframer_crc16_unit
// Byte-serial frame receiver. Frames are header (1 to 4 bytes), 4-byte
// big-endian length, payload, 2-byte big-endian CRC-16/X-25 and tail (1 to
// 4 bytes). One byte is taken per cycle and every payload byte comes out as
// its own result item, delayed by the 2 + tail_length bytes held in the
// trailer window; the byte that completes the tail also yields a status item
// (ok, checksum error or no payload), so one input byte gives at most two
// items. Results pass through a four-entry queue: the input keeps taking a
// byte every cycle as long as the queue holds two items or fewer, so the
// sustained rate is one byte per cycle when the result side takes one item
// per cycle. Registers (APB, byte addresses): 0x0 header_pattern,
// 0x4 header_length, 0x8 tail_pattern, 0xC tail_length; write them only
// while no frame traffic is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_deframer_crc16_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   sdc16_req_if.sink                req_chan,
   sdc16_rsp_if.source              rsp_chan,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [sdc16_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [sdc16_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [sdc16_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                     pready
);
   import sdc16_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   logic     room;
   logic     wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_HEADER_PATTERN: cfg_in.header_pattern = pwdata;
            REG_HEADER_LENGTH:  cfg_in.header_length  = pwdata[MARK_LEN_BITS-1:0];
            REG_TAIL_PATTERN:   cfg_in.tail_pattern   = pwdata;
            REG_TAIL_LENGTH:    cfg_in.tail_length    = pwdata[MARK_LEN_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_pattern <= '0;
         cfg_ff.header_length  <= MARK_LEN_BITS'(1);
         cfg_ff.tail_pattern   <= '0;
         cfg_ff.tail_length    <= MARK_LEN_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (paddr[3:2])
         REG_HEADER_PATTERN: prdata = cfg_ff.header_pattern;
         REG_HEADER_LENGTH:  prdata = CSR_DATA_BITS'(cfg_ff.header_length);
         REG_TAIL_PATTERN:   prdata = cfg_ff.tail_pattern;
         REG_TAIL_LENGTH:    prdata = CSR_DATA_BITS'(cfg_ff.tail_length);
         default:            prdata = '0;
      endcase
   end

   sdc16_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .room     (room),
      .push     (push)
   );

   sdc16_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
